// ===== rtl/core/sctc_pkg.sv =====
// Package: shared types, layout tables and codes for the scan code decoder.
package sctc_pkg;

  typedef enum logic [1:0] {
    KIND_SCAN = 2'd0,
    KIND_TICK = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  localparam logic CFG_DELAY    = 1'b0;
  localparam logic CFG_INTERVAL = 1'b1;

  localparam logic [7:0] NO_CHAR = 8'hFF;
  localparam logic [7:0] PREFIX  = 8'hE0;

  // key slot record: down, extended, hold count
  typedef struct packed {
    logic        down;
    logic        ext;
    logic [15:0] held;
  } slot_t;

  function automatic logic [7:0] plain_map(input logic [6:0] c);
    logic [7:0] v;
    case (c)
      7'd1: v = 8'd27;  7'd2: v = "1"; 7'd3: v = "2"; 7'd4: v = "3"; 7'd5: v = "4";
      7'd6: v = "5"; 7'd7: v = "6"; 7'd8: v = "7"; 7'd9: v = "8"; 7'd10: v = "9";
      7'd11: v = "0"; 7'd12: v = "-"; 7'd13: v = "="; 7'd14: v = 8'd8; 7'd15: v = 8'd9;
      7'd16: v = "q"; 7'd17: v = "w"; 7'd18: v = "e"; 7'd19: v = "r"; 7'd20: v = "t";
      7'd21: v = "y"; 7'd22: v = "u"; 7'd23: v = "i"; 7'd24: v = "o"; 7'd25: v = "p";
      7'd26: v = "["; 7'd27: v = "]"; 7'd28: v = 8'd13;
      7'd30: v = "a"; 7'd31: v = "s"; 7'd32: v = "d"; 7'd33: v = "f"; 7'd34: v = "g";
      7'd35: v = "h"; 7'd36: v = "j"; 7'd37: v = "k"; 7'd38: v = "l"; 7'd39: v = ";";
      7'd40: v = 8'h27; 7'd41: v = "#"; 7'd43: v = 8'h5C;
      7'd44: v = "z"; 7'd45: v = "x"; 7'd46: v = "c"; 7'd47: v = "v"; 7'd48: v = "b";
      7'd49: v = "n"; 7'd50: v = "m"; 7'd51: v = ","; 7'd52: v = "."; 7'd53: v = "/";
      7'd57: v = " ";
      7'd74: v = "-"; 7'd75: v = "4"; 7'd76: v = "5"; 7'd77: v = "6"; 7'd78: v = "+";
      7'd79: v = "1"; 7'd80: v = "2"; 7'd81: v = "3"; 7'd82: v = "0"; 7'd83: v = ".";
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] shift_map(input logic [6:0] c);
    logic [7:0] v;
    case (c)
      7'd2: v = "!"; 7'd3: v = "@"; 7'd4: v = "~"; 7'd5: v = "$"; 7'd6: v = "%";
      7'd7: v = "^"; 7'd8: v = "&"; 7'd9: v = "*"; 7'd10: v = "("; 7'd11: v = ")";
      7'd12: v = "_"; 7'd13: v = "+";
      7'd16: v = "Q"; 7'd17: v = "W"; 7'd18: v = "E"; 7'd19: v = "R"; 7'd20: v = "T";
      7'd21: v = "Y"; 7'd22: v = "U"; 7'd23: v = "I"; 7'd24: v = "O"; 7'd25: v = "P";
      7'd26: v = "{"; 7'd27: v = "}";
      7'd30: v = "A"; 7'd31: v = "S"; 7'd32: v = "D"; 7'd33: v = "F"; 7'd34: v = "G";
      7'd35: v = "H"; 7'd36: v = "J"; 7'd37: v = "K"; 7'd38: v = "L"; 7'd39: v = ":";
      7'd40: v = 8'h22; 7'd41: v = "~"; 7'd43: v = "|";
      7'd44: v = "Z"; 7'd45: v = "X"; 7'd46: v = "C"; 7'd47: v = "V"; 7'd48: v = "B";
      7'd49: v = "N"; 7'd50: v = "M"; 7'd51: v = "<"; 7'd52: v = ">"; 7'd53: v = "?";
      default: v = plain_map(c);
    endcase
    return v;
  endfunction

  function automatic logic is_letter(input logic [7:0] v);
    return (v >= "a" && v <= "z") || (v >= "A" && v <= "Z");
  endfunction

  function automatic logic [7:0] nav_map(input logic [6:0] c);
    logic [7:0] v;
    case (c)
      7'h48: v = 8'h80; 7'h50: v = 8'h81; 7'h4B: v = 8'h82; 7'h4D: v = 8'h83;
      7'h47: v = 8'h84; 7'h4F: v = 8'h85; 7'h49: v = 8'h86; 7'h51: v = 8'h87;
      7'h52: v = 8'h88; 7'h53: v = 8'h89;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // mods: [0] shift [1] ctrl [2] alt [3] caps
  function automatic logic [7:0] translate(input logic [6:0] c, input logic ext,
                                           input logic [3:0] mods);
    logic [7:0] n, s, v;
    n = plain_map(c);
    s = shift_map(c);
    if (ext) v = nav_map(c);
    else if (c == 7'h04 && mods[2]) v = "#";
    else if (n == 8'd0) v = 8'd0;
    else if (mods[3]) begin
      v = mods[0] ? n : s;
      if (!is_letter(v)) v = mods[0] ? s : n;
    end else v = mods[0] ? s : n;
    return v;
  endfunction

endpackage

// ===== rtl/core/sctc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module sctc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/sctc_ring.sv =====
// Character ring: RAM plus pointers, count and pop sequencing.
module sctc_ring #(
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [7:0]               push_data_i,
  input  logic                     pop_i,
  output logic                     full_o,
  output logic                     empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o,
  output logic [7:0]               rdata_o
);
  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  sctc_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk_i, .we_i(push_i), .waddr_i(wr_q), .wdata_i(push_data_i),
    .raddr_i(rd_q), .rdata_o
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

// ===== rtl/core/scancode_to_char_with_repeat.sv =====
// Top level: set-1 scan code decoder with typematic repeat and character ring.
// The decoder takes a new item only once the result of the last one has been taken. A key
// scan byte passes through the scan and output states, while modifier and prefix bytes go
// straight to output; a read passes through the read state unless the ring is empty. A repeat
// tick walks all 128 key slots through the single slot memory, one read then one write-back
// per slot. A held slot whose count lies more than one interval past the window, which only
// happens after the delay or interval registers are lowered, also takes a bit-serial remainder.
// After reset a pass over all 128 slots clears the slot memory before the first item is taken.
module scancode_to_char_with_repeat #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // kind
  input  logic [7:0]  s_axis_tdata,   // scan_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // char_out[7:0] char_valid[8] dropped[9] shift[10] ctrl[11] alt[12] caps[13]
  // fill_level[20:14], zero pad [23:21]
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [14:0] cfg_data_i
);
  import sctc_pkg::*;

  localparam int CW = $clog2(RING_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_READ, ST_TRD, ST_TWR, ST_MOD, ST_MWR, ST_OUT
  } state_e;

  state_e      st_q;
  logic [6:0]  idx_q;
  logic [7:0]  byte_q;
  logic        pre_q, drop_q;
  logic [3:0]  mod_q;
  logic [14:0] dly_q, ivl_q;
  logic [7:0]  ch_q;
  logic        chv_q;
  logic [15:0] num_q, rem_q;
  logic [3:0]  bit_q;

  logic        s_we;
  logic [6:0]  s_waddr, s_raddr;
  slot_t       s_wdata, s_rdata;

  sctc_ram #(.Width($bits(slot_t)), .Depth(128)) u_slots (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  logic          r_push, r_pop, r_full, r_empty;
  logic [7:0]    r_pdata, r_rdata;
  logic [CW-1:0] r_cnt;

  sctc_ring #(.Depth(RING_DEPTH)) u_ring (
    .clk_i, .rst_ni, .push_i(r_push), .push_data_i(r_pdata), .pop_i(r_pop),
    .full_o(r_full), .empty_o(r_empty), .count_o(r_cnt), .rdata_o(r_rdata)
  );

  logic        in_acc;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign s_raddr       = (st_q == ST_IDLE) ? s_axis_tdata[6:0] : idx_q;

  // key bytes go through the slot memory, modifier and prefix bytes do not
  logic        scan_key;
  always_comb begin
    unique case (s_axis_tdata) inside
      8'h2A, 8'h36, 8'hAA, 8'hB6, 8'h3A, 8'hBA, 8'h1D, 8'h9D, 8'h38, 8'hB8,
      PREFIX: scan_key = 1'b0;
      default: scan_key = 1'b1;
    endcase
  end

  // combinational slot work
  logic [7:0]  tch;
  logic [16:0] held1;
  logic [15:0] dd, rr, ph, rem_t;
  logic        want, slow, need_mod;

  always_comb begin
    dd    = (dly_q == '0) ? 16'd1 : {1'b0, dly_q};
    rr    = (ivl_q == '0) ? 16'd1 : {1'b0, ivl_q};
    held1 = {1'b0, s_rdata.held} + 17'd1;
    // one subtract covers counts within one interval past the window
    ph    = 16'(held1 - {1'b0, dd});
    if (ph >= rr) ph = ph - rr;
    slow  = (ph >= rr);
    need_mod = s_rdata.down && held1 != 17'd1 && held1 > {1'b0, dd} && slow;
    rem_t = {rem_q[14:0], num_q[15]};
    if (rem_t >= rr) rem_t = rem_t - rr;
    s_we = 1'b0; s_waddr = idx_q; s_wdata = s_rdata; tch = 8'd0; want = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        s_we = 1'b1; s_wdata = '0;
      end
      ST_SCAN: begin
        if (!byte_q[7]) begin
          if (!s_rdata.down) begin
            s_we = 1'b1;
            s_wdata = '{down: 1'b1, ext: pre_q, held: 16'd0};
            tch = translate(idx_q, pre_q, mod_q);
            want = 1'b1;
          end
        end else begin
          s_we = 1'b1; s_wdata.down = 1'b0;
        end
      end
      ST_TWR: begin
        if (s_rdata.down) begin
          if (held1 == 17'd1 || held1 <= {1'b0, dd}) begin
            s_we = 1'b1;
            s_wdata.held = held1[15:0];
          end else if (!slow) begin
            s_we = 1'b1;
            s_wdata.held = dd + ph;
            if (ph == '0) begin
              tch = translate(idx_q, s_rdata.ext, mod_q);
              want = 1'b1;
            end
          end
        end
      end
      ST_MWR: begin
        s_we = 1'b1;
        s_wdata.held = dd + rem_q;
        if (rem_q == '0) begin
          tch = translate(idx_q, s_rdata.ext, mod_q);
          want = 1'b1;
        end
      end
      default: ;
    endcase
    want    = want && (tch != 8'd0);
    r_push  = want && !r_full;
    r_pdata = tch;
    r_pop   = (st_q == ST_IDLE) && in_acc && s_axis_tuser == KIND_READ && !r_empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; idx_q <= '0; pre_q <= 1'b0; mod_q <= '0; drop_q <= 1'b0;
      dly_q <= 15'd30; ivl_q <= 15'd4; byte_q <= '0;
      chv_q <= 1'b0; ch_q <= NO_CHAR; num_q <= '0; rem_q <= '0; bit_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_DELAY:    dly_q <= cfg_data_i;
          CFG_INTERVAL: ivl_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (want && r_full) drop_q <= 1'b1;
      unique case (st_q)
        ST_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == 7'd127) st_q <= ST_IDLE;
        end
        ST_IDLE: if (in_acc) begin
          byte_q <= s_axis_tdata; drop_q <= 1'b0;
          chv_q <= 1'b0; ch_q <= NO_CHAR; idx_q <= s_axis_tdata[6:0];
          unique case (s_axis_tuser)
            KIND_SCAN: begin
              st_q <= scan_key ? ST_SCAN : ST_OUT;
              if (!scan_key) pre_q <= (s_axis_tdata == PREFIX);
              unique case (s_axis_tdata)
                8'h2A, 8'h36: mod_q[0] <= 1'b1;
                8'hAA, 8'hB6: mod_q[0] <= 1'b0;
                8'h3A: mod_q[3] <= 1'b1;
                8'hBA: mod_q[3] <= 1'b0;
                8'h1D: mod_q[1] <= 1'b1;
                8'h9D: mod_q[1] <= 1'b0;
                8'h38: mod_q[2] <= 1'b1;
                8'hB8: mod_q[2] <= 1'b0;
                default: ;
              endcase
            end
            KIND_TICK: begin idx_q <= '0; st_q <= ST_TRD; end
            KIND_READ: st_q <= r_empty ? ST_OUT : ST_READ;
            default: st_q <= ST_OUT;
          endcase
        end
        ST_SCAN: begin
          pre_q <= 1'b0;
          st_q <= ST_OUT;
        end
        ST_READ: begin ch_q <= r_rdata; chv_q <= 1'b1; st_q <= ST_OUT; end
        ST_TRD: st_q <= ST_TWR;
        ST_TWR: begin
          if (need_mod) begin
            num_q <= ph; rem_q <= '0; bit_q <= '0; st_q <= ST_MOD;
          end else begin
            idx_q <= idx_q + 1'b1;
            st_q <= (idx_q == 7'd127) ? ST_OUT : ST_TRD;
          end
        end
        ST_MOD: begin
          num_q <= {num_q[14:0], 1'b0};
          rem_q <= rem_t;
          bit_q <= bit_q + 1'b1;
          if (bit_q == 4'd15) st_q <= ST_MWR;
        end
        ST_MWR: begin
          idx_q <= idx_q + 1'b1;
          st_q <= (idx_q == 7'd127) ? ST_OUT : ST_TRD;
        end
        ST_OUT: if (m_axis_tready) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (st_q == ST_OUT);
  assign m_axis_tdata  = {3'b000, 7'(r_cnt), mod_q[3], mod_q[2], mod_q[1], mod_q[0],
                          drop_q, chv_q, ch_q};

  // a push never lands while the ring is full
  assert property (@(posedge clk_i) disable iff (!rst_ni) r_full |-> !r_push)
    else $error("push into full ring");
  // pops only happen on a read request from idle with data waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni) r_pop |=> st_q == ST_READ)
    else $error("pop without read sequence");
  // an output without a valid character always carries NO_CHAR
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !chv_q) |-> ch_q == NO_CHAR)
    else $error("stale character on empty read");
  // fill level never exceeds depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) r_cnt <= CW'(RING_DEPTH))
    else $error("ring count overflow");
endmodule

// ===== sim/testbench.sv =====
// Testbench for the set-1 scan code decoder: directed table, then random phases checked by a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sctc_pkg::*;

  localparam int RING_SLOTS  = 64;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic [6:0] fill;
    logic       caps;
    logic       alt;
    logic       ctrl;
    logic       shift;
    logic       lost;
    logic       ok;
    logic [7:0] ch;
  } status_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] code;
    bit         fixed;
    logic [7:0] ch;
    logic       ok;
  } row_t;

  localparam byte unsigned PLAIN[84] = '{
    0, 27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8, 9,
    "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 13, 0,
    "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, "#", 0, 8'h5C,
    "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 0, 0, 0, " ", 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    "-", "4", "5", "6", "+", "1", "2", "3", "0", "."};
  localparam byte unsigned UPPER[84] = '{
    0, 27, "!", "@", "~", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8, 9,
    "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 13, 0,
    "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 0, "|",
    "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 0, 0, 0, " ", 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    "-", "4", "5", "6", "+", "1", "2", "3", "0", "."};
  localparam byte unsigned NAV[10] = '{8'h48, 8'h50, 8'h4B, 8'h4D, 8'h47,
                                       8'h4F, 8'h49, 8'h51, 8'h52, 8'h53};
  localparam byte unsigned MOD_CODES[8] = '{8'h2A, 8'h36, 8'h1D, 8'h38,
                                            8'h3A, 8'hAA, 8'h9D, 8'hB8};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [14:0] cfg_data_i = '0;

  scancode_to_char_with_repeat u_top (.*);

  always #6 clk_i = ~clk_i;

  // decoder state as predicted
  bit         slot_down[128];
  bit         slot_ext[128];
  int         slot_held[128];
  byte unsigned char_fifo[$];
  bit         prefix_seen;
  bit         sh_m, ct_m, al_m, cp_m, lost_now;
  int         delay_ticks = 30;
  int         interval_ticks = 4;

  status_t    status_q[$];
  int         errors = 0;
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         idle_cycles = 0;

  function automatic byte unsigned decode_key(int c, bit ext);
    byte unsigned v;
    if (ext) begin
      for (int i = 0; i < 10; i++) if (NAV[i] == c) return 8'(8'h80 + i);
      return 0;
    end
    if (c == 4 && al_m) return "#";
    if (c >= 84 || PLAIN[c] == 0) return 0;
    if (cp_m) begin
      v = sh_m ? PLAIN[c] : UPPER[c];
      if (!((v >= "a" && v <= "z") || (v >= "A" && v <= "Z")))
        v = sh_m ? UPPER[c] : PLAIN[c];
      return v;
    end
    return sh_m ? UPPER[c] : PLAIN[c];
  endfunction

  function automatic void queue_char(byte unsigned c);
    if (c == 0) return;
    if (char_fifo.size() >= RING_SLOTS) lost_now = 1;
    else char_fifo.push_back(c);
  endfunction

  function automatic status_t decode_step(kind_e k, logic [7:0] b);
    status_t r;
    bit ext;
    int held, ph;
    r.ch = NO_CHAR;
    r.ok = 0;
    lost_now = 0;
    case (k)
      KIND_SCAN: begin
        ext = prefix_seen;
        prefix_seen = 0;
        case (b)
          8'h2A, 8'h36: sh_m = 1;
          8'hAA, 8'hB6: sh_m = 0;
          8'h3A: cp_m = 1;
          8'hBA: cp_m = 0;
          8'h1D: ct_m = 1;
          8'h9D: ct_m = 0;
          8'h38: al_m = 1;
          8'hB8: al_m = 0;
          PREFIX: prefix_seen = 1;
          default: begin
            if (!b[7]) begin
              if (!slot_down[b[6:0]]) begin
                slot_down[b[6:0]] = 1;
                slot_ext[b[6:0]] = ext;
                slot_held[b[6:0]] = 0;
                queue_char(decode_key(b, ext));
              end
            end else slot_down[b[6:0]] = 0;
          end
        endcase
      end
      KIND_TICK: begin
        for (int i = 0; i < 128; i++) begin
          if (!slot_down[i]) continue;
          held = slot_held[i] + 1;
          slot_held[i] = held;
          if (held == 1 || held <= delay_ticks) continue;
          ph = (held - delay_ticks) % interval_ticks;
          slot_held[i] = delay_ticks + ph;
          if (ph == 0) queue_char(decode_key(i, slot_ext[i]));
        end
      end
      KIND_READ: begin
        if (char_fifo.size() > 0) begin
          r.ch = char_fifo.pop_front();
          r.ok = 1;
        end
      end
      default: ;
    endcase
    r.lost  = lost_now;
    r.shift = sh_m;
    r.ctrl  = ct_m;
    r.alt   = al_m;
    r.caps  = cp_m;
    r.fill  = 7'(char_fifo.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // one transfer on the input side; expectation is queued on acceptance
  task automatic send_item(kind_e k, logic [7:0] b, bit fixed = 0,
                           logic [7:0] ch = 0, logic ok = 0);
    status_t e;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    e = decode_step(k, b);
    if (fixed) begin
      e.ch = ch;
      e.ok = ok;
    end
    status_q.push_back(e);
  endtask

  task automatic write_reg(logic idx, int val);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 15'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DELAY) delay_ticks = val ? val : 1;
    else interval_ticks = val ? val : 1;
  endtask

  task automatic random_item();
    int sel;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 22) begin
      b = 8'($urandom_range(127));
      if ($urandom_range(3) == 0) send_item(KIND_SCAN, PREFIX);
      send_item(KIND_SCAN, b);
    end else if (sel < 34) begin
      b = 8'($urandom_range(127));
      send_item(KIND_SCAN, {1'b1, b[6:0]});
    end else if (sel < 42) begin
      if ($urandom_range(4) == 0) send_item(KIND_SCAN, PREFIX);
      send_item(KIND_SCAN, MOD_CODES[$urandom_range(7)]);
    end else if (sel < 62) begin
      send_item(KIND_TICK, 8'($urandom));
    end else if (sel < 94) begin
      send_item(KIND_READ, 8'($urandom));
    end else if (sel < 97) begin
      send_item(KIND_NONE, 8'($urandom));
    end else begin
      send_item(kind_e'($urandom_range(3)), 8'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    status_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = status_t'(m_axis_tdata[20:0]);
      if (status_q.size() == 0) begin
        report_mismatch("unexpected transfer", int'(m_axis_tdata), 0);
      end else begin
        want = status_q.pop_front();
        if (got.ch != want.ch) report_mismatch("char_out", got.ch, want.ch);
        if (got.ok != want.ok) report_mismatch("char_valid", got.ok, want.ok);
        if (got.lost != want.lost) report_mismatch("dropped", got.lost, want.lost);
        if (got.shift != want.shift) report_mismatch("shift", got.shift, want.shift);
        if (got.ctrl != want.ctrl) report_mismatch("ctrl", got.ctrl, want.ctrl);
        if (got.alt != want.alt) report_mismatch("alt", got.alt, want.alt);
        if (got.caps != want.caps) report_mismatch("caps_on", got.caps, want.caps);
        if (got.fill != want.fill) report_mismatch("fill_level", got.fill, want.fill);
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("scancode_to_char_with_repeat regression: fail");
      $finish;
    end
  end

  row_t dir_rows[] = '{
    '{KIND_READ, 8'h00, 1, NO_CHAR, 0},
    '{KIND_NONE, 8'hFF, 1, NO_CHAR, 0},
    '{KIND_SCAN, 8'h1E, 0, 0, 0},
    '{KIND_READ, 8'h00, 1, "a", 1},
    '{KIND_SCAN, 8'h2A, 0, 0, 0},
    '{KIND_SCAN, 8'h10, 0, 0, 0},
    '{KIND_SCAN, 8'h3A, 0, 0, 0},
    '{KIND_SCAN, 8'h02, 0, 0, 0},
    '{KIND_SCAN, 8'h38, 0, 0, 0},
    '{KIND_SCAN, 8'h04, 0, 0, 0},
    '{KIND_SCAN, 8'hB8, 0, 0, 0},
    '{KIND_SCAN, PREFIX, 0, 0, 0},
    '{KIND_SCAN, 8'h48, 0, 0, 0},
    '{KIND_SCAN, PREFIX, 0, 0, 0},
    '{KIND_SCAN, 8'h1D, 0, 0, 0},
    '{KIND_SCAN, 8'h9E, 0, 0, 0},
    '{KIND_SCAN, PREFIX, 0, 0, 0},
    '{KIND_SCAN, 8'h1E, 0, 0, 0},
    '{KIND_SCAN, 8'h00, 0, 0, 0},
    '{KIND_SCAN, 8'h7F, 0, 0, 0},
    '{KIND_SCAN, 8'hFF, 0, 0, 0},
    '{KIND_TICK, 8'h00, 0, 0, 0},
    '{KIND_READ, 8'h00, 0, 0, 0},
    '{KIND_READ, 8'h00, 0, 0, 0},
    '{KIND_READ, 8'h00, 0, 0, 0}
  };

  initial begin
    int delays[5]    = '{30, 1, 2, 32767, 5};
    int intervals[5] = '{4, 1, 3, 32767, 2};
    int src_pct[5]   = '{0, 74, 0, 18, 0};
    int snk_pct[5]   = '{0, 0, 74, 18, 0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].code, dir_rows[i].fixed,
                dir_rows[i].ch, dir_rows[i].ok);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        write_reg(CFG_DELAY, delays[ph]);
        write_reg(CFG_INTERVAL, intervals[ph]);
      end
      src_idle_pct  = src_pct[ph];
      snk_stall_pct = snk_pct[ph];
      for (int n = 0; n < 360; n++) begin
        if (ph == 0 && n == 150) hold_req = hold_req + 1;
        if (ph == 1 && n == 200) begin
          s_axis_tvalid <= 1'b0;
          while (status_q.size() != 0) @(posedge clk_i);
        end
        random_item();
      end
    end
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0)
      $display("scancode_to_char_with_repeat regression: pass");
    else
      $display("scancode_to_char_with_repeat regression: fail");
    $finish;
  end

endmodule
